FILE: hdl/array_index_converter_macros.svh
// Assertion helpers for the index converter; clk_i and rst_ni must be in scope.
`ifndef ARRAY_INDEX_CONVERTER_MACROS_SVH
`define ARRAY_INDEX_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define AIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/aic_pkg.sv
package aic_pkg;

  localparam int NUM_FIELDS   = 4;
  localparam int LIN_W        = 64;
  localparam int SUB_W        = 16;
  localparam int BITS_PER_STG = 4;
  localparam int STG_PER_DIV  = LIN_W / BITS_PER_STG;

  typedef enum logic [2:0] {
    CFG_DIMS = 3'd0,
    CFG_EXT0 = 3'd1,
    CFG_EXT1 = 3'd2,
    CFG_EXT2 = 3'd3,
    CFG_EXT3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                                op;
    logic                                miss;
    logic [2:0]                          n;
    logic [LIN_W-1:0]                    q;
    logic [SUB_W-1:0]                    rem;
    logic [NUM_FIELDS-1:0][SUB_W-1:0]    sub;
  } stg_t;

  typedef struct packed {
    logic [SUB_W-1:0] rem;
    logic [LIN_W-1:0] q;
  } div_t;

  // Restoring division, a few quotient bits per call; rem stays below e.
  function automatic div_t div_step(logic [SUB_W-1:0] rem, logic [LIN_W-1:0] q,
                                    logic [SUB_W-1:0] e);
    logic [SUB_W:0]   r;
    logic [LIN_W-1:0] qq;
    div_t             res;
    r  = {1'b0, rem};
    qq = q;
    for (int i = 0; i < BITS_PER_STG; i++) begin
      r  = {r[SUB_W-1:0], qq[LIN_W-1]};
      qq = {qq[LIN_W-2:0], 1'b0};
      if (r >= {1'b0, e}) begin
        r     = r - {1'b0, e};
        qq[0] = 1'b1;
      end
    end
    res.rem = r[SUB_W-1:0];
    res.q   = qq;
    return res;
  endfunction

endpackage

FILE: hdl/aic_in_if.sv
interface aic_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] linear_in;
  logic        linear_in_missing;
  logic [15:0] sub_in_0;
  logic [15:0] sub_in_1;
  logic [15:0] sub_in_2;
  logic [15:0] sub_in_3;
  logic [3:0]  sub_missing_mask;

  modport source (output valid, operation, linear_in, linear_in_missing, sub_in_0,
                  sub_in_1, sub_in_2, sub_in_3, sub_missing_mask, input ready);
  modport sink (input valid, operation, linear_in, linear_in_missing, sub_in_0,
                sub_in_1, sub_in_2, sub_in_3, sub_missing_mask, output ready);
endinterface

FILE: hdl/aic_out_if.sv
interface aic_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] linear_out;
  logic        result_missing;
  logic [15:0] sub_out_0;
  logic [15:0] sub_out_1;
  logic [15:0] sub_out_2;
  logic [15:0] sub_out_3;

  modport source (output valid, linear_out, result_missing, sub_out_0, sub_out_1,
                  sub_out_2, sub_out_3, input ready);
  modport sink (input valid, linear_out, result_missing, sub_out_0, sub_out_1,
                sub_out_2, sub_out_3, output ready);
endinterface

FILE: hdl/array_index_converter.sv
// Structure: for each dimension of MAX_DIMS (capped at 4), a chain of 4-bit
//   restoring divide stages; linearize beats do Horner multiply-adds in stages 1-3.
// Throughput: one beat per cycle while the output is not stalled.
// Reset: clears all stage valid bits; dims_in_use and every extent return to 1.
// Stalls compress bubbles, so input stays ready while any stage is empty.
`include "array_index_converter_macros.svh"

module array_index_converter
  import aic_pkg::*;
#(
  parameter int MAX_DIMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  aic_in_if.sink      in_i,
  aic_out_if.source   out_o
);

  // Number of division units actually built.
  localparam int NDIV = (MAX_DIMS < NUM_FIELDS) ? MAX_DIMS : NUM_FIELDS;
  localparam int NSTG = NDIV * STG_PER_DIV;

  // Configuration registers.
  logic [2:0]                       dims_q;
  logic [NUM_FIELDS-1:0][SUB_W-1:0] ext_q;
  logic [NUM_FIELDS-1:0][SUB_W-1:0] eff_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 3'd1;
      for (int j = 0; j < NUM_FIELDS; j++) ext_q[j] <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIMS: dims_q   <= cfg_data_i[2:0];
        CFG_EXT0: ext_q[0] <= cfg_data_i;
        CFG_EXT1: ext_q[1] <= cfg_data_i;
        CFG_EXT2: ext_q[2] <= cfg_data_i;
        CFG_EXT3: ext_q[3] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // A zero extent behaves as one.
  always_comb begin
    for (int j = 0; j < NUM_FIELDS; j++) begin
      eff_ext[j] = (ext_q[j] == '0) ? 16'd1 : ext_q[j];
    end
  end

  // Clamp the dimension count to 1..NDIV.
  logic [2:0]            n_c;
  logic [NUM_FIELDS-1:0] used_c;
  always_comb begin
    if (dims_q == 3'd0)              n_c = 3'd1;
    else if (dims_q > 3'(NDIV))      n_c = 3'(NDIV);
    else                             n_c = dims_q;
    for (int j = 0; j < NUM_FIELDS; j++) used_c[j] = (3'(j) < n_c);
  end

  // Build the first stage word. For the subscript sum, start Horner evaluation
  // with the slowest subscript; unused subscripts are zeroed so they add nothing.
  stg_t in_stg;
  always_comb begin
    in_stg        = '0;
    in_stg.op     = in_i.operation;
    in_stg.n      = n_c;
    in_stg.sub[0] = used_c[0] ? in_i.sub_in_0 : '0;
    in_stg.sub[1] = used_c[1] ? in_i.sub_in_1 : '0;
    in_stg.sub[2] = used_c[2] ? in_i.sub_in_2 : '0;
    in_stg.sub[3] = used_c[3] ? in_i.sub_in_3 : '0;
    if (in_i.operation) begin
      in_stg.miss = |(in_i.sub_missing_mask & used_c);
      in_stg.q    = {48'b0, in_stg.sub[3]};
    end else begin
      in_stg.miss = in_i.linear_in_missing;
      in_stg.q    = in_i.linear_in;
    end
  end

  // Pipeline: each stage moves when it is empty or the stage after it moves.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  stg_t            stg_q [NSTG];
  stg_t            stg_d [NSTG];

  assign en[NSTG-1] = !vld_q[NSTG-1] || out_o.ready;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int D = s / STG_PER_DIV;
    localparam int G = s % STG_PER_DIV;

    if (s < NSTG - 1) begin : g_en
      assign en[s] = !vld_q[s] || en[s+1];
    end

    stg_t prv;
    logic prv_vld;
    if (s == 0) begin : g_head
      assign prv     = in_stg;
      assign prv_vld = in_i.valid;
    end else begin : g_body
      assign prv     = stg_q[s-1];
      assign prv_vld = vld_q[s-1];
    end

    always_comb begin
      div_t             ds;
      logic [31:0]      m32;
      logic [47:0]      m48;
      logic [LIN_W-1:0] m64;
      stg_d[s] = prv;
      ds  = '0;
      m32 = '0;
      m48 = '0;
      m64 = '0;
      if (!prv.op) begin
        // Advance the divide of this dimension by a few quotient bits.
        ds = div_step((G == 0) ? '0 : prv.rem, prv.q, eff_ext[D]);
        stg_d[s].q   = ds.q;
        stg_d[s].rem = ds.rem;
        if (G == STG_PER_DIV - 1) stg_d[s].sub[D] = ds.rem;
      end else if (s == 1) begin
        m32 = eff_ext[2] * prv.q[15:0];
        stg_d[s].q = {32'b0, m32} + {48'b0, prv.sub[2]};
      end else if (s == 2) begin
        m48 = eff_ext[1] * prv.q[31:0];
        stg_d[s].q = {16'b0, m48} + {48'b0, prv.sub[1]};
      end else if (s == 3) begin
        m64 = eff_ext[0] * prv.q[47:0];
        stg_d[s].q = m64 + {48'b0, prv.sub[0]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en[s]) begin
        vld_q[s] <= prv_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign in_i.ready = en[0];

  // Output beat comes straight from the last stage register.
  stg_t last;
  logic sub_ok;
  assign last   = stg_q[NSTG-1];
  assign sub_ok = !last.op && !last.miss;

  assign out_o.valid          = vld_q[NSTG-1];
  assign out_o.result_missing = last.miss;
  assign out_o.linear_out     = (last.op && !last.miss) ? last.q : '0;
  assign out_o.sub_out_0      = (sub_ok && last.n > 3'd0) ? last.sub[0] : '0;
  assign out_o.sub_out_1      = (sub_ok && last.n > 3'd1) ? last.sub[1] : '0;
  assign out_o.sub_out_2      = (sub_ok && last.n > 3'd2) ? last.sub[2] : '0;
  assign out_o.sub_out_3      = (sub_ok && last.n > 3'd3) ? last.sub[3] : '0;

  // Any empty stage must let a new beat in.
  `AIC_ASSERT_NOW(a_ready_on_bubble, !(&vld_q), in_i.ready, "bubble present but input stalled")
  // A stalled result stays in the last stage.
  `AIC_ASSERT_NEXT(a_hold_result, out_o.valid && !out_o.ready, out_o.valid, "stalled result lost")
  // An accepted beat lands in the first stage.
  `AIC_ASSERT_NEXT(a_enter, in_i.valid && in_i.ready, vld_q[0], "accepted beat not captured")

endmodule
